[sv/gwlos_pkg.sv]
// shared constants, codes and controller/datapath interface structs for the grid
// line-of-sight core; depends on nothing
package gwlos_pkg;

  // map geometry
  localparam int MAP_DIM  = 32;
  localparam int DEPTH    = MAP_DIM * MAP_DIM;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int SIZE_W   = $clog2(MAP_DIM + 1);
  localparam int USED_RST = (32 > MAP_DIM) ? MAP_DIM : 32;

  // field widths
  localparam int POS_W      = 5;
  localparam int BITS_W     = 8;
  localparam int OFS_W      = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  // walk arithmetic widths
  localparam int COORD_W = 8;
  localparam int ABS_W   = 5;
  localparam int ERR_W   = 8;
  localparam int STEP_W  = 7;

  // command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 2'd1;

  // directions
  typedef logic [1:0] dir_t;
  localparam dir_t DIR_N = 2'd0;
  localparam dir_t DIR_E = 2'd1;
  localparam dir_t DIR_S = 2'd2;
  localparam dir_t DIR_W = 2'd3;

  // probe index of the last map read of a step
  localparam logic [1:0] PRB_LAST_EDGE   = 2'd1;
  localparam logic [1:0] PRB_LAST_CORNER = 2'd3;

  typedef enum logic [1:0] {
    KIND_X,
    KIND_Y,
    KIND_CORNER
  } step_kind_t;

  typedef struct packed {
    logic       clr_step;
    logic       wr_cell;
    logic       load_query;
    logic       setup;
    logic       probe_en;
    logic [1:0] probe_idx;
    logic       step_upd;
  } ctl_cmd_t;

  typedef struct packed {
    logic       clr_done;
    logic       zero_off;
    step_kind_t kind;
    logic       blocked;
    logic       walk_done;
  } dp_stat_t;

endpackage

[sv/grid_wall_line_of_sight_core.sv]
// top level of the grid line-of-sight core: joins controller and datapath
// depends on gwlos_pkg, gwlos_ctrl, gwlos_dp
//
// Usage: after reset the core sweeps its 1024-entry map store to all-open, one
// entry per cycle, and holds busy high for the whole sweep; the config port
// is always ready, also during the sweep. An item transfers when start is high
// and busy is low. A map write (in_cmd 0) lands in that same cycle, gives no
// result and leaves busy low, so writes can stream one per cycle. A query
// (in_cmd 1) raises busy; its single result appears on out_visible for exactly
// one cycle with out_valid high and cannot be held off, so the receiver must
// take it then. Busy falls in the cycle the result is shown. A query with a
// zero offset answers straight from the setup state. Otherwise the walk runs a
// setup state and then, per walk step, a probe for each map read and a check
// state: two reads for a straight step and four for a corner step; the single
// read port of the map memory sets this pace. The walk stops at the first
// closed edge or when its steps run out.
module grid_wall_line_of_sight_core (
  input  logic                               clk,
  input  logic                               rst_n,
  // command channel
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_cmd,
  input  logic [gwlos_pkg::POS_W-1:0]        in_pos_x,
  input  logic [gwlos_pkg::POS_W-1:0]        in_pos_y,
  input  logic [gwlos_pkg::BITS_W-1:0]       in_cell_bits,
  input  logic [1:0]                         in_facing,
  input  logic signed [gwlos_pkg::OFS_W-1:0] in_ahead,
  input  logic signed [gwlos_pkg::OFS_W-1:0] in_side,
  // result strobe
  output logic                               out_valid,
  output logic                               out_visible,
  // config write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [gwlos_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gwlos_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import gwlos_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // config registers take a write in any cycle
  assign cfg_ready = 1'b1;

  // controller: sequences the clear sweep and the walk, owns the result strobe
  gwlos_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_cmd      (in_cmd),
    .busy        (busy),
    .out_valid   (out_valid),
    .out_visible (out_visible),
    .cmd         (cmd),
    .stat        (stat)
  );

  // datapath: map memory, walk registers and edge checks
  gwlos_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_pos_x     (in_pos_x),
    .in_pos_y     (in_pos_y),
    .in_cell_bits (in_cell_bits),
    .in_facing    (in_facing),
    .in_ahead     (in_ahead),
    .in_side      (in_side),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  // a result strobe only ever follows a cycle in which a query was in flight
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a query in flight");

  // an accepted query keeps the core busy in the next cycle
  a_query_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd == CMD_QUERY) |=> busy)
    else $error("query transfer did not raise busy");

  // a map write gives no result
  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd == CMD_WRITE) |=> !out_valid)
    else $error("map write produced a result");

  // one result per query: the strobe is never held high
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

endmodule

[sv/gwlos_dp.sv]
// datapath of the grid line-of-sight core: map memory, config registers, walk
// registers and edge checks; depends on gwlos_pkg
module gwlos_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  gwlos_pkg::ctl_cmd_t              cmd,
  output gwlos_pkg::dp_stat_t              stat,
  input  logic [gwlos_pkg::POS_W-1:0]      in_pos_x,
  input  logic [gwlos_pkg::POS_W-1:0]      in_pos_y,
  input  logic [gwlos_pkg::BITS_W-1:0]     in_cell_bits,
  input  logic [1:0]                       in_facing,
  input  logic signed [gwlos_pkg::OFS_W-1:0] in_ahead,
  input  logic signed [gwlos_pkg::OFS_W-1:0] in_side,
  input  logic                             cfg_we,
  input  logic [gwlos_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gwlos_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import gwlos_pkg::*;

  function automatic logic [3:0] dir_mask(input dir_t d);
    dir_mask = 4'b0001 << d;
  endfunction

  function automatic dir_t dir_opp(input dir_t d);
    dir_opp = d + 2'd2;
  endfunction

  // map store
  logic [BITS_W-1:0] mem [DEPTH];
  logic [BITS_W-1:0] rdata_r;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [BITS_W-1:0] wdata;
  logic [ADDR_W-1:0] raddr;

  // control registers
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [SIZE_W-1:0] used_w_r, used_w_nxt;
  logic [SIZE_W-1:0] used_h_r, used_h_nxt;
  logic              blocked_r, blocked_nxt;
  logic              pv_r;

  // walk registers
  logic signed [COORD_W-1:0] cx_r, cx_nxt;
  logic signed [COORD_W-1:0] cy_r, cy_nxt;
  logic signed [COORD_W-1:0] tx_r, tx_nxt;
  logic signed [COORD_W-1:0] ty_r, ty_nxt;
  logic                      zero_r, zero_nxt;
  logic [ABS_W-1:0]          adx_r, adx_nxt;
  logic [ABS_W-1:0]          ady_r, ady_nxt;
  dir_t                      sx_r, sx_nxt;
  dir_t                      sy_r, sy_nxt;
  logic signed [ERR_W-1:0]   err_r, err_nxt;
  logic signed [STEP_W-1:0]  steps_r, steps_nxt;
  logic [3:0]                pmask_r;
  logic                      pin_r;

  logic signed [COORD_W-1:0] px_ext, py_ext, ah_ext, sd_ext;
  logic signed [COORD_W-1:0] dxs, dys, xs, ys, prx, pry;
  logic signed [COORD_W-1:0] size_w_s, size_h_s;
  logic signed [ERR_W-1:0]   tw_adx, tw_ady;
  logic [ABS_W-1:0]          adx_set, ady_set;
  step_kind_t                kind;
  logic                      ox, oy, p_in, fail;
  logic [3:0]                pmask;
  logic                      pos_ok;
  logic [SIZE_W-1:0]         cfg_used;

  // ---- target and direction setup ----
  assign px_ext = $signed(COORD_W'(in_pos_x));
  assign py_ext = $signed(COORD_W'(in_pos_y));
  assign ah_ext = COORD_W'(in_ahead);
  assign sd_ext = COORD_W'(in_side);

  assign dxs     = tx_r - cx_r;
  assign dys     = ty_r - cy_r;
  assign adx_set = (dxs < 0) ? ABS_W'(-dxs) : ABS_W'(dxs);
  assign ady_set = (dys < 0) ? ABS_W'(-dys) : ABS_W'(dys);

  assign tw_adx = $signed(ERR_W'({adx_r, 1'b0}));
  assign tw_ady = $signed(ERR_W'({ady_r, 1'b0}));

  assign xs = (sx_r == DIR_E) ? COORD_W'(1) : -COORD_W'(1);
  assign ys = (sy_r == DIR_S) ? COORD_W'(1) : -COORD_W'(1);

  always_comb begin
    if (err_r > 0 || ady_r == '0) begin
      kind = KIND_X;
    end else if (err_r < 0 || adx_r == '0) begin
      kind = KIND_Y;
    end else begin
      kind = KIND_CORNER;
    end
  end

  // ---- probe selection: cell offset and edge mask ----
  always_comb begin
    ox    = 1'b0;
    oy    = 1'b0;
    pmask = '0;
    case (kind)
      KIND_X: begin
        if (cmd.probe_idx == 2'd0) begin
          pmask = dir_mask(sx_r);
        end else begin
          ox    = 1'b1;
          pmask = dir_mask(dir_opp(sx_r));
        end
      end
      KIND_Y: begin
        if (cmd.probe_idx == 2'd0) begin
          pmask = dir_mask(sy_r);
        end else begin
          oy    = 1'b1;
          pmask = dir_mask(dir_opp(sy_r));
        end
      end
      KIND_CORNER: begin
        case (cmd.probe_idx)
          2'd0: begin
            pmask = dir_mask(sx_r) | dir_mask(sy_r);
          end
          2'd1: begin
            ox    = 1'b1;
            pmask = dir_mask(dir_opp(sx_r)) | dir_mask(sy_r);
          end
          2'd2: begin
            oy    = 1'b1;
            pmask = dir_mask(sx_r) | dir_mask(dir_opp(sy_r));
          end
          default: begin
            ox    = 1'b1;
            oy    = 1'b1;
            pmask = dir_mask(dir_opp(sx_r)) | dir_mask(dir_opp(sy_r));
          end
        endcase
      end
      default: begin
        pmask = '0;
      end
    endcase
  end

  assign prx      = ox ? (cx_r + xs) : cx_r;
  assign pry      = oy ? (cy_r + ys) : cy_r;
  assign size_w_s = $signed(COORD_W'(used_w_r));
  assign size_h_s = $signed(COORD_W'(used_h_r));
  assign p_in     = (prx >= 0) && (pry >= 0) && (prx < size_w_s) && (pry < size_h_s);

  assign raddr = p_in ? (ADDR_W'(pry) * ADDR_W'(MAP_DIM) + ADDR_W'(prx)) : '0;

  // ---- edge evaluation, in the cycle after the read ----
  assign fail = pv_r && (!pin_r || (((rdata_r[3:0] | rdata_r[7:4]) & pmask_r) != 4'b0000));

  // ---- memory write port: clear sweep or cell write ----
  assign pos_ok = (int'(in_pos_x) < MAP_DIM) && (int'(in_pos_y) < MAP_DIM);
  assign we     = cmd.clr_step || (cmd.wr_cell && pos_ok);
  assign waddr  = cmd.clr_step ? clr_cnt_r
                               : (ADDR_W'(in_pos_y) * ADDR_W'(MAP_DIM) + ADDR_W'(in_pos_x));
  assign wdata  = cmd.clr_step ? '0 : in_cell_bits;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  // ---- config ----
  assign cfg_used = (int'(cfg_wdata) > MAP_DIM) ? SIZE_W'(MAP_DIM) : SIZE_W'(cfg_wdata);

  always_comb begin
    used_w_nxt = used_w_r;
    used_h_nxt = used_h_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_MAP_WIDTH:  used_w_nxt = cfg_used;
        REG_MAP_HEIGHT: used_h_nxt = cfg_used;
        default: begin
          used_w_nxt = used_w_r;
        end
      endcase
    end
  end

  assign clr_cnt_nxt = cmd.clr_step ? (clr_cnt_r + ADDR_W'(1)) : clr_cnt_r;
  assign blocked_nxt = cmd.setup ? 1'b0 : (blocked_r | fail);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      used_w_r  <= SIZE_W'(USED_RST);
      used_h_r  <= SIZE_W'(USED_RST);
      blocked_r <= 1'b0;
      pv_r      <= 1'b0;
    end else begin
      clr_cnt_r <= clr_cnt_nxt;
      used_w_r  <= used_w_nxt;
      used_h_r  <= used_h_nxt;
      blocked_r <= blocked_nxt;
      pv_r      <= cmd.probe_en;
    end
  end

  // ---- walk registers ----
  always_comb begin
    cx_nxt    = cx_r;
    cy_nxt    = cy_r;
    tx_nxt    = tx_r;
    ty_nxt    = ty_r;
    zero_nxt  = zero_r;
    adx_nxt   = adx_r;
    ady_nxt   = ady_r;
    sx_nxt    = sx_r;
    sy_nxt    = sy_r;
    err_nxt   = err_r;
    steps_nxt = steps_r;
    if (cmd.load_query) begin
      cx_nxt   = px_ext;
      cy_nxt   = py_ext;
      zero_nxt = (in_ahead == '0) && (in_side == '0);
      case (in_facing)
        DIR_N: begin
          tx_nxt = px_ext + sd_ext;
          ty_nxt = py_ext - ah_ext;
        end
        DIR_E: begin
          tx_nxt = px_ext + ah_ext;
          ty_nxt = py_ext + sd_ext;
        end
        DIR_S: begin
          tx_nxt = px_ext - sd_ext;
          ty_nxt = py_ext + ah_ext;
        end
        default: begin
          tx_nxt = px_ext - ah_ext;
          ty_nxt = py_ext - sd_ext;
        end
      endcase
    end else if (cmd.setup) begin
      adx_nxt   = adx_set;
      ady_nxt   = ady_set;
      sx_nxt    = (dxs > 0) ? DIR_E : DIR_W;
      sy_nxt    = (dys > 0) ? DIR_S : DIR_N;
      err_nxt   = $signed(ERR_W'(adx_set)) - $signed(ERR_W'(ady_set));
      steps_nxt = $signed(STEP_W'(adx_set)) + $signed(STEP_W'(ady_set));
    end else if (cmd.step_upd) begin
      case (kind)
        KIND_X: begin
          cx_nxt    = cx_r + xs;
          err_nxt   = err_r - tw_ady;
          steps_nxt = steps_r - STEP_W'(1);
        end
        KIND_Y: begin
          cy_nxt    = cy_r + ys;
          err_nxt   = err_r + tw_adx;
          steps_nxt = steps_r - STEP_W'(1);
        end
        default: begin
          cx_nxt    = cx_r + xs;
          cy_nxt    = cy_r + ys;
          err_nxt   = err_r + tw_adx - tw_ady;
          steps_nxt = steps_r - STEP_W'(2);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    cx_r    <= cx_nxt;
    cy_r    <= cy_nxt;
    tx_r    <= tx_nxt;
    ty_r    <= ty_nxt;
    zero_r  <= zero_nxt;
    adx_r   <= adx_nxt;
    ady_r   <= ady_nxt;
    sx_r    <= sx_nxt;
    sy_r    <= sy_nxt;
    err_r   <= err_nxt;
    steps_r <= steps_nxt;
    pmask_r <= pmask;
    pin_r   <= p_in;
  end

  // ---- status ----
  assign stat.clr_done  = (clr_cnt_r == ADDR_W'(DEPTH - 1));
  assign stat.zero_off  = zero_r;
  assign stat.kind      = kind;
  assign stat.blocked   = blocked_r | fail;
  assign stat.walk_done = !(steps_r > 0);

endmodule

[sv/gwlos_ctrl.sv]
// controller of the grid line-of-sight core: clear sweep, command decode and
// walk sequencing; depends on gwlos_pkg
module gwlos_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                in_cmd,
  output logic                busy,
  output logic                out_valid,
  output logic                out_visible,
  output gwlos_pkg::ctl_cmd_t cmd,
  input  gwlos_pkg::dp_stat_t stat
);
  import gwlos_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_PROBE,
    ST_CHECK
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] prb_r, prb_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_visible_r, out_visible_nxt;
  logic [1:0] prb_last;

  assign prb_last = (stat.kind == KIND_CORNER) ? PRB_LAST_CORNER : PRB_LAST_EDGE;

  always_comb begin
    state_nxt       = state_r;
    prb_nxt         = prb_r;
    out_valid_nxt   = 1'b0;
    out_visible_nxt = out_visible_r;
    cmd             = '0;
    cmd.probe_idx   = prb_r;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (in_cmd == CMD_QUERY) begin
            cmd.load_query = 1'b1;
            state_nxt      = ST_SETUP;
          end else begin
            cmd.wr_cell = 1'b1;
          end
        end
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        prb_nxt   = 2'd0;
        if (stat.zero_off) begin
          out_valid_nxt   = 1'b1;
          out_visible_nxt = 1'b1;
          state_nxt       = ST_IDLE;
        end else begin
          state_nxt = ST_PROBE;
        end
      end
      ST_PROBE: begin
        cmd.probe_en = 1'b1;
        if (prb_r == prb_last) begin
          cmd.step_upd = 1'b1;
          state_nxt    = ST_CHECK;
        end else begin
          prb_nxt = prb_r + 2'd1;
        end
      end
      ST_CHECK: begin
        prb_nxt = 2'd0;
        if (stat.blocked || stat.walk_done) begin
          out_valid_nxt   = 1'b1;
          out_visible_nxt = !stat.blocked;
          state_nxt       = ST_IDLE;
        end else begin
          state_nxt = ST_PROBE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      prb_r         <= 2'd0;
      out_valid_r   <= 1'b0;
      out_visible_r <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      prb_r         <= prb_nxt;
      out_valid_r   <= out_valid_nxt;
      out_visible_r <= out_visible_nxt;
    end
  end

  assign busy        = (state_r != ST_IDLE);
  assign out_valid   = out_valid_r;
  assign out_visible = out_visible_r;

endmodule
